// File: hdl/assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CPIO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("check failed");
`define CPIO_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error("bad state");
`else
`define CPIO_ASSERT(lbl, prop)
`define CPIO_NEVER(lbl, expr)
`endif
`endif

// File: hdl/cpio_pkg.sv
package cpio_pkg;

  localparam int unsigned ImageSlots = 64;
  localparam int unsigned NameLimit  = 128;
  localparam int unsigned HdrLen     = 110;
  localparam int unsigned FsizePos   = 54;
  localparam int unsigned NsizePos   = 94;

  localparam logic [2:0] PH_FIRST    = 3'd0;
  localparam logic [2:0] PH_HDR      = 3'd1;
  localparam logic [2:0] PH_NAME     = 3'd2;
  localparam logic [2:0] PH_NAME_PAD = 3'd3;
  localparam logic [2:0] PH_DATA     = 3'd4;
  localparam logic [2:0] PH_DATA_PAD = 3'd5;
  localparam logic [2:0] PH_IDLE     = 3'd6;

  localparam logic [3:0] M_LEAD     = 4'd0;
  localparam logic [3:0] M_WS       = 4'd1;
  localparam logic [3:0] M_SIGN     = 4'd2;
  localparam logic [3:0] M_ZERO     = 4'd3;
  localparam logic [3:0] M_HEXPFX   = 4'd4;
  localparam logic [3:0] M_DEC      = 4'd5;
  localparam logic [3:0] M_OCT      = 4'd6;
  localparam logic [3:0] M_HEX      = 4'd7;
  localparam logic [3:0] M_STOP     = 4'd8;
  localparam logic [3:0] M_END_NONE = 4'd9;
  localparam logic [3:0] M_END_TOK  = 4'd10;

  localparam logic [2:0] EV_PAYLOAD  = 3'd0;
  localparam logic [2:0] EV_START    = 3'd1;
  localparam logic [2:0] EV_FINISHED = 3'd2;
  localparam logic [2:0] EV_NOT_ARC  = 3'd3;
  localparam logic [2:0] EV_ERROR    = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TRUNC     = 3'd1;
  localparam logic [2:0] ERR_MAGIC     = 3'd2;
  localparam logic [2:0] ERR_NAME_LEN  = 3'd3;
  localparam logic [2:0] ERR_UNTERM    = 3'd4;
  localparam logic [2:0] ERR_NO_ID     = 3'd5;
  localparam logic [2:0] ERR_BAD_ID    = 3'd6;
  localparam logic [2:0] ERR_NON_HEX   = 3'd7;

  typedef struct packed {
    logic        last;
    logic [7:0]  data_byte;
    logic [31:0] entry_size;
    logic [5:0]  image_id;
    logic [2:0]  error_code;
    logic [2:0]  event_res;
  } res_t;

  function automatic logic [7:0] magic_char(input logic [2:0] i);
    logic [7:0] ch;
    case (i)
      3'd1, 3'd3: ch = 8'h37;
      3'd5:       ch = 8'h31;
      default:    ch = 8'h30;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [3:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = 8'h54;
      4'd1:    ch = 8'h52;
      4'd2:    ch = 8'h41;
      4'd3:    ch = 8'h49;
      4'd4:    ch = 8'h4c;
      4'd5:    ch = 8'h45;
      4'd6:    ch = 8'h52;
      default: ch = 8'h21;
    endcase
    return ch;
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] h;
    if (c >= 8'h30 && c <= 8'h39) h = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      h = {1'b0, c[3:0] + 4'd9};
    else h = 5'h10;
    return h;
  endfunction

  function automatic res_t mk_res(input logic [2:0] ev, input logic [2:0] err,
                                  input logic [5:0] id, input logic [31:0] sz,
                                  input logic [7:0] d, input logic lst);
    res_t r;
    r.event_res  = ev;
    r.error_code = err;
    r.image_id   = id;
    r.entry_size = sz;
    r.data_byte  = d;
    r.last       = lst;
    return r;
  endfunction

endpackage

// File: hdl/cpio_newc_image_unpacker_top.sv
// Channel   Dir  Fields (low bit up)
// s_axis    in   tdata: in_byte[7:0]
// m_axis    out  tdata: error_code, image_id, entry_size, data_byte, zero fill;
//                tuser: event_res; tlast: entry_last
// cfg       in   cfg_wdata_i: archive_length
// One input beat is taken per cycle while the queue has room; its results land in a four-deep result queue.
// A beat yields up to two results, so input is taken while the queue holds two or fewer.
// Reset clears the parser state and empties the queue; archive_length resets to zero.
// Output stalls hold results in the queue; once it holds more than two, input is stalled too.
module cpio_newc_image_unpacker_top #(
  parameter int unsigned IMAGE_SLOTS = cpio_pkg::ImageSlots,
  parameter int unsigned NAME_LIMIT  = cpio_pkg::NameLimit
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // error_code, image_id, entry_size, data_byte
  output logic [2:0]  m_axis_tuser,   // event_res
  output logic        m_axis_tlast    // entry_last
);
  import cpio_pkg::*;

  `include "assert_macros.svh"

  logic [31:0] len_q;
  logic [2:0]  ph_q, ph_d;
  logic [31:0] off_q, off_d;
  logic [7:0]  fld_q, fld_d;
  logic [31:0] sacc_q, sacc_d;
  logic [31:0] nlen_q, nlen_d;
  logic [31:0] drem_q, drem_d;
  logic [31:0] idv_q, idv_d;
  logic [3:0]  mode_q, mode_d;
  logic        tm_q, tm_d;
  logic [5:0]  cid_q, cid_d;

  res_t        fifo_q [4];
  logic [1:0]  wp_q, rp_q;
  logic [2:0]  cnt_q;
  res_t        r0, r1;
  logic [1:0]  npush;
  logic        acc, pop;

  logic [7:0]  c;
  logic [32:0] nxt;
  logic [33:0] al;
  logic [4:0]  hv;
  logic [3:0]  fm;
  logic [31:0] fv;
  logic [35:0] a8, a10, a16;
  logic [3:0]  dg;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign pop = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q <= 3'd2);
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign c   = s_axis_tdata;
  assign nxt = {1'b0, off_q} + 33'd1;
  assign al  = ({1'b0, nxt} + 34'd3) & ~34'd3;
  assign hv  = hex_val(c);
  assign dg  = (c >= 8'h30 && c <= 8'h39) ? c[3:0] : hv[3:0];
  assign a8  = {1'b0, idv_q, 3'b0} + {32'd0, dg};
  assign a10 = {1'b0, idv_q, 3'b0} + {3'b0, idv_q, 1'b0} + {32'd0, dg};
  assign a16 = {idv_q, 4'b0} + {32'd0, dg};

  always_comb begin
    logic [3:0] md;
    logic [35:0] av;
    logic        upd;
    md  = mode_q;
    fm  = mode_q;
    fv  = idv_q;
    av  = '0;
    upd = 1'b0;
    if (mode_q < M_END_NONE) begin
      if (c == 8'h00) begin
        fm = (mode_q == M_LEAD) ? M_END_NONE : M_END_TOK;
      end else if (!(mode_q == M_LEAD && c == 8'h3a)) begin
        if (md == M_LEAD) md = M_WS;
        fm = md;
        if (md == M_WS && (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d))) begin
          fm = M_WS;
        end else if (md == M_WS && c == 8'h2b) begin
          fm = M_SIGN;
        end else if (md == M_WS && c == 8'h2d) begin
          fv = '0;
          fm = M_STOP;
        end else begin
          case (md)
            M_WS, M_SIGN: begin
              if (c == 8'h30) fm = M_ZERO;
              else if (c >= 8'h31 && c <= 8'h39) begin
                av = a10; upd = 1'b1; fm = M_DEC;
              end else fm = M_STOP;
            end
            M_ZERO: begin
              if (c == 8'h78 || c == 8'h58) fm = M_HEXPFX;
              else if (c >= 8'h30 && c <= 8'h37) begin
                av = a8; upd = 1'b1; fm = M_OCT;
              end else fm = M_STOP;
            end
            M_HEXPFX, M_HEX: begin
              if (!hv[4]) begin
                av = a16; upd = 1'b1; fm = M_HEX;
              end else fm = M_STOP;
            end
            M_DEC: begin
              if (c >= 8'h30 && c <= 8'h39) begin
                av = a10; upd = 1'b1;
              end else fm = M_STOP;
            end
            M_OCT: begin
              if (c >= 8'h30 && c <= 8'h37) begin
                av = a8; upd = 1'b1;
              end else fm = M_STOP;
            end
            default: fm = md;
          endcase
        end
      end
    end
    if (upd) fv = (av[35:32] != 4'd0) ? 32'hFFFF_FFFF : av[31:0];
  end

  always_comb begin
    logic        tm;
    logic [31:0] nl;
    logic [34:0] s1, s2;
    logic        hdr_fail;
    ph_d   = ph_q;
    off_d  = off_q;
    fld_d  = fld_q;
    sacc_d = sacc_q;
    nlen_d = nlen_q;
    drem_d = drem_q;
    idv_d  = idv_q;
    mode_d = mode_q;
    tm_d   = tm_q;
    cid_d  = cid_q;
    r0     = '0;
    r1     = '0;
    npush  = 2'd0;
    tm     = tm_q;
    nl     = nlen_q - 32'd1;
    s1     = {2'b0, nxt} + {3'b0, nlen_q};
    s2     = s1 + {3'b0, drem_q};
    hdr_fail = (al + 34'(HdrLen)) > {2'b0, len_q};
    if (acc && ph_q != PH_IDLE) begin
      off_d = off_q + 32'd1;
      case (ph_q)
        PH_FIRST, PH_HDR: begin
          if (ph_q == PH_FIRST && fld_q == 8'd0 && len_q < 32'(HdrLen)) begin
            r0 = mk_res(EV_NOT_ARC, ERR_NONE, '0, '0, '0, 1'b0); npush = 2'd1;
            ph_d = PH_IDLE;
          end else if (fld_q < 8'd6 && c != magic_char(fld_q[2:0])) begin
            r0 = (ph_q == PH_FIRST) ? mk_res(EV_NOT_ARC, ERR_NONE, '0, '0, '0, 1'b0)
                                   : mk_res(EV_ERROR, ERR_MAGIC, '0, '0, '0, 1'b0);
            npush = 2'd1;
            ph_d = PH_IDLE;
          end else if (((fld_q >= 8'(FsizePos) && fld_q < 8'(FsizePos + 8)) ||
                        (fld_q >= 8'(NsizePos) && fld_q < 8'(NsizePos + 8))) && hv[4]) begin
            r0 = mk_res(EV_ERROR, ERR_NON_HEX, '0, '0, '0, 1'b0); npush = 2'd1;
            ph_d = PH_IDLE;
          end else begin
            if ((fld_q >= 8'(FsizePos) && fld_q < 8'(FsizePos + 8)) ||
                (fld_q >= 8'(NsizePos) && fld_q < 8'(NsizePos + 8))) begin
              if (fld_q == 8'(FsizePos) || fld_q == 8'(NsizePos))
                sacc_d = {28'd0, hv[3:0]};
              else sacc_d = {sacc_q[27:0], hv[3:0]};
              if (fld_q == 8'(FsizePos + 7)) drem_d = sacc_d;
              if (fld_q == 8'(NsizePos + 7)) nlen_d = sacc_d;
            end
            if (fld_q < 8'(HdrLen - 1)) begin
              fld_d = fld_q + 8'd1;
            end else if (s1 > {3'b0, len_q} || s2 > {3'b0, len_q}) begin
              r0 = mk_res(EV_ERROR, ERR_TRUNC, '0, '0, '0, 1'b0); npush = 2'd1;
              ph_d = PH_IDLE;
            end else if (nlen_q == 32'd0 || nlen_q > 32'(NAME_LIMIT)) begin
              r0 = mk_res(EV_ERROR, ERR_NAME_LEN, '0, '0, '0, 1'b0); npush = 2'd1;
              ph_d = PH_IDLE;
            end else begin
              fld_d  = '0;
              idv_d  = '0;
              mode_d = M_LEAD;
              tm_d   = 1'b1;
              ph_d   = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          if (mode_q < M_END_NONE) begin
            if (c == 8'h00) begin
              if (fld_q != 8'd10) tm = 1'b0;
            end else if (fld_q >= 8'd10 || c != trailer_char(fld_q[3:0])) begin
              tm = 1'b0;
            end
          end
          tm_d   = tm;
          mode_d = fm;
          idv_d  = fv;
          if (fld_q != 8'd255) fld_d = fld_q + 8'd1;
          nlen_d = nl;
          if (nl == 32'd0) begin
            npush = 2'd1;
            ph_d  = PH_IDLE;
            if (c != 8'h00) r0 = mk_res(EV_ERROR, ERR_UNTERM, '0, '0, '0, 1'b0);
            else if (tm) r0 = mk_res(EV_FINISHED, ERR_NONE, '0, '0, '0, 1'b0);
            else if (fm == M_END_NONE) r0 = mk_res(EV_ERROR, ERR_NO_ID, '0, '0, '0, 1'b0);
            else if (fv < 32'd1 || fv >= 32'(IMAGE_SLOTS))
              r0 = mk_res(EV_ERROR, ERR_BAD_ID, '0, '0, '0, 1'b0);
            else if (({1'b0, al} + {3'b0, drem_q}) > {3'b0, len_q})
              r0 = mk_res(EV_ERROR, ERR_TRUNC, '0, '0, '0, 1'b0);
            else begin
              cid_d = fv[5:0];
              r0 = mk_res(EV_START, ERR_NONE, fv[5:0], drem_q, '0, drem_q == 32'd0);
              if (drem_q == 32'd0) begin
                if (hdr_fail) begin
                  r1 = mk_res(EV_ERROR, ERR_TRUNC, '0, '0, '0, 1'b0); npush = 2'd2;
                end else begin
                  fld_d = '0;
                  ph_d  = (al != {1'b0, nxt}) ? PH_DATA_PAD : PH_HDR;
                end
              end else begin
                ph_d = (al != {1'b0, nxt}) ? PH_NAME_PAD : PH_DATA;
              end
            end
          end
        end
        PH_NAME_PAD: begin
          if (nxt[1:0] == 2'd0) ph_d = PH_DATA;
        end
        PH_DATA: begin
          r0 = mk_res(EV_PAYLOAD, ERR_NONE, cid_q, '0, c, drem_q <= 32'd1);
          npush = 2'd1;
          if (drem_q > 32'd1) begin
            drem_d = drem_q - 32'd1;
          end else begin
            drem_d = '0;
            if (hdr_fail) begin
              r1 = mk_res(EV_ERROR, ERR_TRUNC, '0, '0, '0, 1'b0); npush = 2'd2;
              ph_d = PH_IDLE;
            end else begin
              fld_d = '0;
              ph_d  = (al != {1'b0, nxt}) ? PH_DATA_PAD : PH_HDR;
            end
          end
        end
        PH_DATA_PAD: begin
          if (nxt[1:0] == 2'd0) begin
            fld_d = '0;
            ph_d  = PH_HDR;
          end
        end
        default: ph_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ph_q   <= PH_FIRST;
      off_q  <= '0;
      fld_q  <= '0;
      sacc_q <= '0;
      nlen_q <= '0;
      drem_q <= '0;
      idv_q  <= '0;
      mode_q <= M_LEAD;
      tm_q   <= 1'b1;
      cid_q  <= '0;
      wp_q   <= '0;
      rp_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) len_q <= cfg_wdata_i;
      ph_q   <= ph_d;
      off_q  <= off_d;
      fld_q  <= fld_d;
      sacc_q <= sacc_d;
      nlen_q <= nlen_d;
      drem_q <= drem_d;
      idv_q  <= idv_d;
      mode_q <= mode_d;
      tm_q   <= tm_d;
      cid_q  <= cid_d;
      wp_q   <= wp_q + npush;
      if (pop) rp_q <= rp_q + 2'd1;
      cnt_q  <= cnt_q + {1'b0, npush} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (npush != 2'd0) fifo_q[wp_q] <= r0;
    if (npush == 2'd2) fifo_q[wp_q + 2'd1] <= r1;
  end

  assign m_axis_tdata = {7'd0, fifo_q[rp_q].data_byte, fifo_q[rp_q].entry_size,
                         fifo_q[rp_q].image_id, fifo_q[rp_q].error_code};
  assign m_axis_tuser = fifo_q[rp_q].event_res;
  assign m_axis_tlast = fifo_q[rp_q].last;

  `CPIO_NEVER(a_cnt_range, cnt_q > 3'd4)
  `CPIO_ASSERT(a_room_on_accept, acc |-> cnt_q <= 3'd2)
  `CPIO_ASSERT(a_idle_sticks, ph_q == PH_IDLE |=> ph_q == PH_IDLE)
  `CPIO_ASSERT(a_two_only_at_end, npush == 2'd2 |-> (ph_q == PH_DATA || ph_q == PH_NAME))

endmodule
